FILE: rtl/dtd_pkg.sv
`timescale 1ns / 1ps
package dtd_pkg;
    localparam int MaxEntries = 1024;
    localparam int MaxEntryLen = 32;
    localparam int IdW = 10;
    localparam int OffW = 5;
    localparam int LenW = 6;
    localparam int AddrW = IdW + OffW;
    localparam logic [31:0] LiteralLimit = 32'h4000_0000;

    localparam logic [1:0] KindByte = 2'd0;
    localparam logic [1:0] KindDone = 2'd1;
    localparam logic [1:0] KindError = 2'd2;

    localparam logic [3:0] ErrNone = 4'd0;
    localparam logic [3:0] ErrSignature = 4'd1;
    localparam logic [3:0] ErrTruncated = 4'd2;
    localparam logic [3:0] ErrMode = 4'd3;
    localparam logic [3:0] ErrIdWidth = 4'd4;
    localparam logic [3:0] ErrCount = 4'd5;
    localparam logic [3:0] ErrEntryLong = 4'd6;
    localparam logic [3:0] ErrReference = 4'd7;
    localparam logic [3:0] ErrToken = 4'd8;
    localparam logic [3:0] ErrLiteralLong = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic [3:0] error_code;
        logic       last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             len_we;
        logic [IdW-1:0]   len_addr;
        logic [LenW-1:0]  len_wdata;
        logic             byte_we;
        logic [AddrW-1:0] byte_waddr;
        logic [7:0]       byte_wdata;
        logic             len_re;
        logic [IdW-1:0]   len_raddr;
        logic             byte_re;
        logic [AddrW-1:0] byte_raddr;
    } t_dp_cmd;

    typedef struct packed {
        logic [LenW-1:0] len_rdata;
        logic [7:0]      byte_rdata;
    } t_dp_stat;
endpackage

FILE: rtl/dtd_ram.sv
`timescale 1ns / 1ps
module dtd_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/dtd_datapath.sv
`timescale 1ns / 1ps
module dtd_datapath (
    input  logic              i_clk,
    input  dtd_pkg::t_dp_cmd  i_cmd,
    output dtd_pkg::t_dp_stat o_stat
);
    import dtd_pkg::*;

    dtd_ram #(.Width(LenW), .Depth(MaxEntries)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.len_we),
        .i_waddr (i_cmd.len_addr),
        .i_wdata (i_cmd.len_wdata),
        .i_re    (i_cmd.len_re),
        .i_raddr (i_cmd.len_raddr),
        .o_rdata (o_stat.len_rdata)
    );

    dtd_ram #(.Width(8), .Depth(MaxEntries * MaxEntryLen)) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.byte_we),
        .i_waddr (i_cmd.byte_waddr),
        .i_wdata (i_cmd.byte_wdata),
        .i_re    (i_cmd.byte_re),
        .i_raddr (i_cmd.byte_raddr),
        .o_rdata (o_stat.byte_rdata)
    );
endmodule

FILE: rtl/dtd_ctrl.sv
`timescale 1ns / 1ps
module dtd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtd_pkg::t_out_item o_out_data,
    output dtd_pkg::t_dp_cmd   o_cmd,
    input  dtd_pkg::t_dp_stat  i_stat
);
    import dtd_pkg::*;

    typedef enum logic [3:0] {
        PH_SIG, PH_MODE, PH_RAW_LEN, PH_RAW_DATA, PH_RAW_DONE, PH_ID_WIDTH,
        PH_COUNT, PH_ENTRY_LEN, PH_ENTRY_DATA, PH_TOKEN, PH_REF, PH_LIT_LEN,
        PH_LIT_DATA, PH_ERROR, PH_LEN_RD, PH_EXPAND
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [1:0]   r_fidx, n_fidx;
    logic [31:0]  r_acc, n_acc;
    logic         r_wide, n_wide;
    logic [10:0]  r_total, n_total;
    logic [10:0]  r_loaded, n_loaded;
    logic [LenW-1:0] r_fill, n_fill;
    logic [LenW-1:0] r_cur_len, n_cur_len;
    logic [31:0]  r_remain, n_remain;
    logic [IdW-1:0] r_id, n_id;
    logic [LenW-1:0] r_k, n_k;
    logic [LenW-1:0] r_elen, n_elen;
    logic         r_pend, n_pend;
    logic         r_ovalid, n_ovalid;
    t_out_item    r_odata, n_odata;
    t_dp_cmd      cmd;

    logic         accept;
    logic         out_free;
    logic [31:0]  gathered;
    logic [1:0]   fidx_inc;
    logic         busy;

    assign out_free = !r_ovalid || !i_out_stall;
    assign busy = (r_phase == PH_LEN_RD) || (r_phase == PH_EXPAND);
    assign o_in_stall = busy || !out_free;
    assign accept = i_in_valid && !o_in_stall;
    assign fidx_inc = r_fidx + 2'd1;
    assign gathered = r_acc | ({24'd0, i_in_data.data_byte} << {r_fidx, 3'b000});
    assign o_out_valid = r_ovalid;
    assign o_out_data = r_odata;
    assign o_cmd = cmd;

    always_comb begin
        logic [7:0] b;
        logic [7:0] sig;
        b = i_in_data.data_byte;
        n_phase = r_phase; n_fidx = r_fidx; n_acc = r_acc; n_wide = r_wide;
        n_total = r_total; n_loaded = r_loaded; n_fill = r_fill;
        n_cur_len = r_cur_len; n_remain = r_remain; n_id = r_id; n_k = r_k;
        n_elen = r_elen; n_pend = r_pend;
        n_ovalid = r_ovalid && i_out_stall;
        n_odata = r_odata;
        cmd = '0;
        case (r_fidx)
            2'd0: sig = 8'h42;
            2'd1: sig = 8'h43;
            2'd2: sig = 8'h32;
            default: sig = 8'h31;
        endcase
        if (accept && i_in_data.end_of_stream) begin
            n_odata = '{out_byte: 8'd0, result_kind: KindError,
                        error_code: ErrTruncated, last: 1'b1};
            n_ovalid = 1'b1;
            case (r_phase)
                PH_ERROR: n_ovalid = 1'b0;
                PH_TOKEN, PH_RAW_DONE: begin
                    n_odata.result_kind = KindDone;
                    n_odata.error_code = ErrNone;
                end
                PH_SIG: n_odata.error_code = ErrSignature;
                PH_ID_WIDTH: n_odata.error_code = ErrIdWidth;
                default: ;
            endcase
            n_phase = PH_SIG; n_fidx = '0; n_acc = '0; n_wide = 1'b0;
            n_total = '0; n_loaded = '0; n_fill = '0; n_remain = '0;
        end else if (accept) begin
            n_odata = '{out_byte: 8'd0, result_kind: KindError,
                        error_code: ErrNone, last: 1'b1};
            case (r_phase)
                PH_SIG: begin
                    if (b != sig) begin
                        n_odata.error_code = ErrSignature;
                    end else if (r_fidx == 2'd3) begin
                        n_phase = PH_MODE; n_fidx = '0; n_acc = '0;
                    end else begin
                        n_fidx = fidx_inc[1:0];
                    end
                end
                PH_MODE: begin
                    if (b == 8'd0) begin
                        n_phase = PH_RAW_LEN; n_fidx = '0; n_acc = '0;
                    end else if (b == 8'd1) begin
                        n_phase = PH_ID_WIDTH;
                    end else begin
                        n_odata.error_code = ErrMode;
                    end
                end
                PH_RAW_LEN, PH_LIT_LEN: begin
                    n_acc = gathered; n_fidx = fidx_inc[1:0];
                    if (r_fidx == 2'd3) begin
                        n_remain = gathered;
                        if (r_phase == PH_LIT_LEN && gathered > LiteralLimit) begin
                            n_odata.error_code = ErrLiteralLong;
                        end else if (gathered == 32'd0) begin
                            n_phase = (r_phase == PH_RAW_LEN) ? PH_RAW_DONE : PH_TOKEN;
                        end else begin
                            n_phase = (r_phase == PH_RAW_LEN) ? PH_RAW_DATA : PH_LIT_DATA;
                        end
                    end
                end
                PH_RAW_DATA, PH_LIT_DATA: begin
                    n_odata = '{out_byte: b, result_kind: KindByte,
                                error_code: ErrNone, last: 1'b1};
                    n_ovalid = 1'b1;
                    n_remain = r_remain - 32'd1;
                    if (r_remain == 32'd1) begin
                        n_phase = (r_phase == PH_RAW_DATA) ? PH_RAW_DONE : PH_TOKEN;
                    end
                end
                PH_ID_WIDTH: begin
                    if (b == 8'd1 || b == 8'd2) begin
                        n_wide = (b == 8'd2);
                        n_phase = PH_COUNT; n_fidx = '0; n_acc = '0;
                    end else begin
                        n_odata.error_code = ErrIdWidth;
                    end
                end
                PH_COUNT: begin
                    n_acc = gathered; n_fidx = fidx_inc[1:0];
                    if (r_fidx == 2'd3) begin
                        if (gathered == 32'd0 || gathered > 32'(MaxEntries)) begin
                            n_odata.error_code = ErrCount;
                        end else begin
                            n_total = gathered[10:0]; n_loaded = '0;
                            n_phase = PH_ENTRY_LEN; n_fidx = '0; n_acc = '0;
                        end
                    end
                end
                PH_ENTRY_LEN: begin
                    n_acc = gathered; n_fidx = fidx_inc[1:0];
                    if (r_fidx == 2'd3) begin
                        if (gathered > 32'(MaxEntryLen)) begin
                            n_odata.error_code = ErrEntryLong;
                        end else begin
                            cmd.len_we = 1'b1;
                            cmd.len_addr = r_loaded[IdW-1:0];
                            cmd.len_wdata = gathered[LenW-1:0];
                            n_cur_len = gathered[LenW-1:0];
                            n_fill = '0;
                            if (gathered == 32'd0) begin
                                n_loaded = r_loaded + 11'd1;
                                if (r_loaded + 11'd1 >= r_total) begin
                                    n_phase = PH_TOKEN;
                                end else begin
                                    n_phase = PH_ENTRY_LEN; n_fidx = '0; n_acc = '0;
                                end
                            end else begin
                                n_phase = PH_ENTRY_DATA;
                            end
                        end
                    end
                end
                PH_ENTRY_DATA: begin
                    cmd.byte_we = 1'b1;
                    cmd.byte_waddr = {r_loaded[IdW-1:0], r_fill[OffW-1:0]};
                    cmd.byte_wdata = b;
                    n_fill = r_fill + LenW'(1);
                    if (r_fill + LenW'(1) >= r_cur_len) begin
                        n_loaded = r_loaded + 11'd1;
                        if (r_loaded + 11'd1 >= r_total) begin
                            n_phase = PH_TOKEN;
                        end else begin
                            n_phase = PH_ENTRY_LEN; n_fidx = '0; n_acc = '0;
                        end
                    end
                end
                PH_TOKEN: begin
                    if (b == 8'd1) begin
                        n_phase = PH_REF; n_fidx = '0; n_acc = '0;
                    end else if (b == 8'd0) begin
                        n_phase = PH_LIT_LEN; n_fidx = '0; n_acc = '0;
                    end else begin
                        n_odata.error_code = ErrToken;
                    end
                end
                PH_REF: begin
                    n_acc = gathered; n_fidx = fidx_inc[1:0];
                    if (!r_wide || r_fidx == 2'd1) begin
                        if (gathered >= {21'd0, r_total}) begin
                            n_odata.error_code = ErrReference;
                        end else begin
                            n_id = gathered[IdW-1:0];
                            cmd.len_re = 1'b1;
                            cmd.len_raddr = gathered[IdW-1:0];
                            n_phase = PH_LEN_RD;
                        end
                    end
                end
                default: ;
            endcase
            if (n_odata.result_kind == KindError && n_odata.error_code != ErrNone) begin
                n_ovalid = 1'b1;
                n_phase = PH_ERROR;
            end
        end else if (r_phase == PH_LEN_RD) begin
            n_elen = i_stat.len_rdata;
            n_k = '0;
            n_pend = 1'b0;
            if (i_stat.len_rdata == '0) begin
                n_phase = PH_TOKEN;
            end else begin
                n_phase = PH_EXPAND;
            end
        end else if (r_phase == PH_EXPAND) begin
            // A read is in flight while r_pend is set; it is delivered when the output is free.
            if (r_pend) begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata = '{out_byte: i_stat.byte_rdata, result_kind: KindByte,
                                error_code: ErrNone, last: (r_k == r_elen)};
                    n_pend = 1'b0;
                    if (r_k == r_elen) n_phase = PH_TOKEN;
                end
            end else begin
                cmd.byte_re = 1'b1;
                cmd.byte_raddr = {r_id, r_k[OffW-1:0]};
                n_k = r_k + LenW'(1);
                n_pend = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG; r_fidx <= '0; r_acc <= '0; r_wide <= 1'b0;
            r_total <= '0; r_loaded <= '0; r_fill <= '0; r_remain <= '0;
            r_pend <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_fidx <= n_fidx; r_acc <= n_acc; r_wide <= n_wide;
            r_total <= n_total; r_loaded <= n_loaded; r_fill <= n_fill;
            r_remain <= n_remain; r_pend <= n_pend; r_ovalid <= n_ovalid;
        end
        r_cur_len <= n_cur_len; r_id <= n_id; r_k <= n_k; r_elen <= n_elen;
        r_odata <= n_odata;
    end
endmodule

FILE: rtl/dictionary_token_decompressor_unit.sv
`timescale 1ns / 1ps
// Dictionary token decompressor. One transaction on the input channel carries
// one compressed byte or an end-of-stream marker; one transaction on the output
// channel carries a restored byte, a success result or a numbered error.
// Header, raw and literal bytes are accepted while the output register is free,
// with the result showing in the output register in the cycle after acceptance.
// A dictionary reference holds off input while the entry length is read, then
// while each entry byte is read from the entry byte memory, whose read is
// registered, and delivered; an empty entry returns straight to token decoding.
// Entry bytes are written into memory as they arrive and are read back only
// within the stream that loaded them, so the memories need no clearing.
// Reset is synchronous and active low; afterwards the block waits for a
// signature and accepts input on the next cycle.
// When the receiver stalls, the output register holds its transaction and the
// input channel is stalled until the register drains.
module dictionary_token_decompressor_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtd_pkg::t_out_item o_out_data
);
    import dtd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    dtd_datapath u_dp (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .o_stat (stat)
    );
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import dtd_pkg::*;

    typedef enum logic [3:0] {
        PhSig, PhMode, PhRawLen, PhRawData, PhRawDone, PhIdWidth, PhCount,
        PhEntryLen, PhEntryData, PhToken, PhRef, PhLitLen, PhLitData, PhError
    } t_phase;

    localparam int CycleLimit = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;

    dictionary_token_decompressor_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // Decoder state mirrored from the stream format.
    t_phase      dec_phase;
    logic [1:0]  dec_index;
    logic [31:0] dec_acc;
    logic        dec_wide;
    logic [10:0] dec_total;
    logic [10:0] dec_loaded;
    logic [5:0]  dec_fill;
    logic [31:0] dec_remaining;
    logic [7:0]  dict_bytes [MaxEntries*MaxEntryLen];
    logic [5:0]  dict_lengths [MaxEntries];

    t_out_item   pending_results [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          cycles = 0;
    int          idle_pct = 10;
    bit          hold_off = 1'b0;
    int          streams_sent = 0;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        case (idx)
            2'd0: return 8'h42;
            2'd1: return 8'h43;
            2'd2: return 8'h32;
            default: return 8'h31;
        endcase
    endfunction

    task automatic add_result(inout t_out_item res[$], input logic [7:0] b,
                              input logic [1:0] kind, input logic [3:0] code);
        t_out_item r;
        r.out_byte = b;
        r.result_kind = kind;
        r.error_code = code;
        r.last = 1'b0;
        res.insert(res.size(), r);
    endtask

    task automatic raise_error(inout t_out_item res[$], input logic [3:0] code);
        add_result(res, 8'h00, KindError, code);
        dec_phase = PhError;
    endtask

    task automatic restart_decoder();
        dec_phase = PhSig;
        dec_index = '0;
        dec_acc = '0;
        dec_wide = 1'b0;
        dec_total = '0;
        dec_loaded = '0;
        dec_fill = '0;
        dec_remaining = '0;
    endtask

    task automatic open_field(input t_phase nxt);
        dec_phase = nxt;
        dec_index = '0;
        dec_acc = '0;
    endtask

    function automatic bit take_field_byte(input logic [7:0] b, input int want);
        dec_acc = dec_acc | (32'(b) << (8 * dec_index));
        dec_index = dec_index + 2'd1;
        return (dec_index == 2'(want)) || (want == 4 && dec_index == 2'd0);
    endfunction

    task automatic finish_entry();
        dec_loaded = dec_loaded + 11'd1;
        if (dec_loaded >= dec_total) begin
            dec_phase = PhToken;
        end else begin
            open_field(PhEntryLen);
        end
    endtask

    task automatic decode_item(input t_in_item it);
        t_out_item res[$];
        logic [7:0] b;
        int id;
        b = it.data_byte;
        if (it.end_of_stream) begin
            case (dec_phase)
                PhError: ;
                PhToken, PhRawDone: add_result(res, 8'h00, KindDone, ErrNone);
                PhSig: add_result(res, 8'h00, KindError, ErrSignature);
                PhIdWidth: add_result(res, 8'h00, KindError, ErrIdWidth);
                default: add_result(res, 8'h00, KindError, ErrTruncated);
            endcase
            restart_decoder();
        end else begin
            case (dec_phase)
                PhSig: begin
                    if (b != sig_byte(dec_index)) begin
                        raise_error(res, ErrSignature);
                    end else if (dec_index == 2'd3) begin
                        open_field(PhMode);
                    end else begin
                        dec_index = dec_index + 2'd1;
                    end
                end
                PhMode: begin
                    if (b == 8'd0) open_field(PhRawLen);
                    else if (b == 8'd1) dec_phase = PhIdWidth;
                    else raise_error(res, ErrMode);
                end
                PhRawLen: begin
                    if (take_field_byte(b, 4)) begin
                        dec_remaining = dec_acc;
                        dec_phase = (dec_acc != 0) ? PhRawData : PhRawDone;
                    end
                end
                PhRawData: begin
                    add_result(res, b, KindByte, ErrNone);
                    dec_remaining = dec_remaining - 1;
                    if (dec_remaining == 0) dec_phase = PhRawDone;
                end
                PhIdWidth: begin
                    if (b == 8'd1 || b == 8'd2) begin
                        dec_wide = (b == 8'd2);
                        open_field(PhCount);
                    end else begin
                        raise_error(res, ErrIdWidth);
                    end
                end
                PhCount: begin
                    if (take_field_byte(b, 4)) begin
                        if (dec_acc == 0 || dec_acc > MaxEntries) begin
                            raise_error(res, ErrCount);
                        end else begin
                            dec_total = 11'(dec_acc);
                            dec_loaded = '0;
                            open_field(PhEntryLen);
                        end
                    end
                end
                PhEntryLen: begin
                    if (take_field_byte(b, 4)) begin
                        if (dec_acc > MaxEntryLen) begin
                            raise_error(res, ErrEntryLong);
                        end else begin
                            dict_lengths[dec_loaded] = 6'(dec_acc);
                            dec_fill = '0;
                            if (dec_acc == 0) finish_entry();
                            else dec_phase = PhEntryData;
                        end
                    end
                end
                PhEntryData: begin
                    dict_bytes[dec_loaded*MaxEntryLen + dec_fill] = b;
                    dec_fill = dec_fill + 6'd1;
                    if (dec_fill >= dict_lengths[dec_loaded]) finish_entry();
                end
                PhToken: begin
                    if (b == 8'd1) open_field(PhRef);
                    else if (b == 8'd0) open_field(PhLitLen);
                    else raise_error(res, ErrToken);
                end
                PhRef: begin
                    if (take_field_byte(b, dec_wide ? 2 : 1)) begin
                        id = int'(dec_acc);
                        if (id >= dec_total) begin
                            raise_error(res, ErrReference);
                        end else begin
                            for (int k = 0; k < dict_lengths[id]; k++)
                                add_result(res, dict_bytes[id*MaxEntryLen + k],
                                           KindByte, ErrNone);
                            dec_phase = PhToken;
                        end
                    end
                end
                PhLitLen: begin
                    if (take_field_byte(b, 4)) begin
                        if (dec_acc > LiteralLimit) begin
                            raise_error(res, ErrLiteralLong);
                        end else begin
                            dec_remaining = dec_acc;
                            dec_phase = (dec_acc != 0) ? PhLitData : PhToken;
                        end
                    end
                end
                PhLitData: begin
                    add_result(res, b, KindByte, ErrNone);
                    dec_remaining = dec_remaining - 1;
                    if (dec_remaining == 0) dec_phase = PhToken;
                end
                default: ;
            endcase
        end
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) pending_results.insert(pending_results.size(), res[i]);
    endtask

    task automatic report_mismatch(input string what, input t_out_item got,
                                   input t_out_item want);
        string got_txt;
        string want_txt;
        mismatches++;
        got_txt = $sformatf("got byte=%02h kind=%0d code=%0d last=%0b",
                            got.out_byte, got.result_kind, got.error_code, got.last);
        want_txt = $sformatf("want byte=%02h kind=%0d code=%0d last=%0b",
                             want.out_byte, want.result_kind, want.error_code, want.last);
        $display("MISMATCH %s: %s, %s", what, got_txt, want_txt);
    endtask

    // Sends one byte, or an end marker, and predicts its results on acceptance.
    task automatic send_item(input logic [7:0] b, input bit eos);
        t_in_item it;
        it.data_byte = b;
        it.end_of_stream = eos;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        decode_item(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_end();
        send_item(8'h00, 1'b1);
        streams_sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
    endtask

    task automatic send_header(input logic [7:0] mode);
        send_byte(8'h42);
        send_byte(8'h43);
        send_byte(8'h32);
        send_byte(8'h31);
        send_byte(mode);
    endtask

    // Dictionary stream with random entries and a random mix of tokens.
    task automatic send_dictionary_stream(input int entries, input bit wide,
                                          input int tokens, input int max_len);
        int len;
        int id;
        send_header(8'd1);
        send_byte(wide ? 8'd2 : 8'd1);
        send_word(32'(entries));
        for (int e = 0; e < entries; e++) begin
            len = $urandom_range(max_len);
            send_word(32'(len));
            for (int k = 0; k < len; k++) send_byte(8'($urandom));
        end
        for (int t = 0; t < tokens; t++) begin
            if ($urandom_range(2) != 0) begin
                send_byte(8'd1);
                id = ($urandom_range(19) == 0) ? entries + $urandom_range(3)
                                               : $urandom_range(entries - 1);
                send_byte(id[7:0]);
                if (wide) send_byte(id[15:8]);
            end else begin
                send_byte(8'd0);
                len = $urandom_range(5);
                send_word(32'(len));
                for (int k = 0; k < len; k++) send_byte(8'($urandom));
            end
        end
        send_end();
    endtask

    task automatic test_raw_streams();
        send_header(8'd0);
        send_word(32'd4);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h77);
        send_end();
        send_header(8'd0);
        send_word(32'd0);
        send_end();
    endtask

    task automatic test_header_errors();
        send_end();
        send_byte(8'h42);
        send_byte(8'h00);
        send_byte(8'h11);
        send_end();
        send_byte(8'h42);
        send_end();
        send_header(8'd7);
        send_end();
        send_header(8'd1);
        send_end();
        send_header(8'd1);
        send_byte(8'd3);
        send_end();
        send_header(8'd1);
        send_byte(8'd1);
        send_word(32'd0);
        send_end();
        send_header(8'd1);
        send_byte(8'd1);
        send_word(32'd1025);
        send_end();
        send_header(8'd0);
        send_word(32'd3);
        send_byte(8'h01);
        send_end();
    endtask

    task automatic test_dictionary_errors();
        send_header(8'd1);
        send_byte(8'd1);
        send_word(32'd1);
        send_word(32'd33);
        send_end();
        send_header(8'd1);
        send_byte(8'd2);
        send_word(32'd2);
        send_word(32'd32);
        for (int k = 0; k < 32; k++) send_byte(8'(k * 7));
        send_word(32'd0);
        send_byte(8'd1);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'd1);
        send_byte(8'd1);
        send_byte(8'd0);
        send_byte(8'd0);
        send_word(32'h4000_0001);
        send_end();
        send_header(8'd1);
        send_byte(8'd1);
        send_word(32'd1);
        send_word(32'd1);
        send_byte(8'hC3);
        send_byte(8'd9);
        send_end();
        send_header(8'd1);
        send_byte(8'd1);
        send_word(32'd1);
        send_word(32'd0);
        send_byte(8'd1);
        send_byte(8'd5);
        send_end();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        send_dictionary_stream(4, 1'b0, 20, 32);
    endtask

    task automatic test_random_streams();
        int sel;
        while (items_sent < 460) begin
            idle_pct = (items_sent > 370 && items_sent < 430) ? 0 : 10;
            sel = $urandom_range(9);
            if (sel < 5) begin
                send_dictionary_stream($urandom_range(1, 4), sel[0], $urandom_range(1, 6), 8);
            end else if (sel < 7) begin
                send_header(8'd0);
                send_word(32'($urandom_range(6)));
                for (int k = $urandom_range(7); k > 0; k--) send_byte(8'($urandom));
                send_end();
            end else begin
                for (int k = $urandom_range(1, 6); k > 0; k--)
                    send_byte(($urandom_range(3) == 0) ? 8'($urandom) : sig_byte(2'(k)));
                send_end();
            end
        end
        idle_pct = 10;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= hold_off || (idle_pct != 0 && $urandom_range(99) < idle_pct);
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_out_data, '0);
                end else if (o_out_data !== pending_results[0]) begin
                    report_mismatch("field", o_out_data, pending_results[0]);
                    void'(pending_results.pop_front());
                end else begin
                    void'(pending_results.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        restart_decoder();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_raw_streams();
        test_header_errors();
        test_dictionary_errors();
        test_backpressure();
        test_random_streams();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d input transactions in %0d streams; checked %0d results.",
                 items_sent, streams_sent, results_seen);
        $display("Covered raw and dictionary streams, every error code and long output stalls.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
